@@ sv/rational_distortion_map_defines.svh @@
// Assertion macros shared by the rational distortion map RTL.
`ifndef RATIONAL_DISTORTION_MAP_DEFINES_SVH
`define RATIONAL_DISTORTION_MAP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define RDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rdm_pkg.sv @@
// Shared types, constants and helper functions of the rational distortion map.
package rdm_pkg;

	localparam int MAX_ORDER_DEF = 4;
	localparam int ORD_W  = 3;
	localparam int POLY_W = 2;
	localparam int IDX_W  = 4;
	localparam int COEF_W = 32;
	localparam int PT_W   = 16;
	localparam int OUT_W  = 32;
	localparam int ST_W   = 2;
	localparam int PW_W   = 32;
	localparam int TERM_W = 39;
	localparam int NPOLY  = 3;
	localparam int QB     = 32;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MAP  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_DEN_ZERO = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT      = 2'd2;

	localparam int POLY_XN  = 0;
	localparam int POLY_YN  = 1;
	localparam int POLY_DEN = 2;

	localparam logic signed [COEF_W-1:0] ONE_Q24 = 32'sh0100_0000;
	localparam logic signed [PW_W-1:0]   ONE_Q30 = 32'sh4000_0000;
	localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic vld;
		logic map;
	} ctl_t;

	typedef struct packed {
		logic [POLY_W-1:0] poly;
		logic [IDX_W-1:0]  idx;
		logic [COEF_W-1:0] val;
	} load_t;

	function automatic int terms_of(input int ord);
		return ((ord + 1) * (ord + 2)) >> 1;
	endfunction

	function automatic int deg_of(input int n);
		int d;
		d = 0;
		for (int o = 0; o < 16; o++) begin
			if (terms_of(o) <= n) d = o + 1;
		end
		return d;
	endfunction

	function automatic int jx_of(input int n);
		int d;
		d = deg_of(n);
		return (d == 0) ? n : n - terms_of(d - 1);
	endfunction

	function automatic logic [COEF_W-1:0] init_coef(input int p, input int n);
		logic hit;
		hit = (p == POLY_XN && n == 2) || (p == POLY_YN && n == 1) || (p == POLY_DEN && n == 0);
		return hit ? ONE_Q24 : '0;
	endfunction

endpackage

@@ sv/rdm_in_if.sv @@
// Request channel of the rational distortion map.
interface rdm_in_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [rdm_pkg::POLY_W-1:0]        coef_poly;
	logic [rdm_pkg::IDX_W-1:0]         coef_index;
	logic signed [rdm_pkg::COEF_W-1:0] coef_value;
	logic signed [rdm_pkg::PT_W-1:0]   x_in;
	logic signed [rdm_pkg::PT_W-1:0]   y_in;

	modport source (output valid, mode, coef_poly, coef_index, coef_value, x_in, y_in,
		input ready);
	modport sink (input valid, mode, coef_poly, coef_index, coef_value, x_in, y_in,
		output ready);
endinterface

@@ sv/rdm_out_if.sv @@
// Result channel of the rational distortion map.
interface rdm_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [rdm_pkg::OUT_W-1:0] x_out;
	logic signed [rdm_pkg::OUT_W-1:0] y_out;
	logic [rdm_pkg::ST_W-1:0]         status;

	modport source (output valid, x_out, y_out, status, input ready);
	modport sink (input valid, x_out, y_out, status, output ready);
endinterface

@@ sv/rdm_pow.sv @@
// Power pipeline: one stage per degree computes the next powers of x and y.
module rdm_pow #(
	parameter int MAX_ORDER = rdm_pkg::MAX_ORDER_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           adv,
	input  rdm_pkg::ctl_t                                  ctl_in,
	input  rdm_pkg::load_t                                 ld_in,
	input  logic [rdm_pkg::PT_W-1:0]                       x_in,
	input  logic [rdm_pkg::PT_W-1:0]                       y_in,
	output rdm_pkg::ctl_t                                  ctl_out,
	output rdm_pkg::load_t                                 ld_out,
	output logic [MAX_ORDER:0][rdm_pkg::PW_W-1:0]          px_out,
	output logic [MAX_ORDER:0][rdm_pkg::PW_W-1:0]          py_out
);
	import rdm_pkg::*;

	localparam logic signed [PW_W+PT_W-1:0] RND15 = (PW_W+PT_W)'(1) << 14;

	typedef struct packed {
		load_t                       ld;
		logic [PT_W-1:0]             x;
		logic [PT_W-1:0]             y;
		logic [MAX_ORDER:0][PW_W-1:0] px;
		logic [MAX_ORDER:0][PW_W-1:0] py;
	} pst_t;

	pst_t st_in;
	pst_t st_s  [1:MAX_ORDER];
	ctl_t ctl_s [1:MAX_ORDER];

	always_comb begin
		st_in.ld    = ld_in;
		st_in.x     = x_in;
		st_in.y     = y_in;
		st_in.px    = '0;
		st_in.py    = '0;
		st_in.px[0] = ONE_Q30;
		st_in.py[0] = ONE_Q30;
	end

	for (genvar o = 1; o <= MAX_ORDER; o++) begin : g_stage
		pst_t prv;
		pst_t nxt;
		ctl_t prv_ctl;
		logic signed [PW_W+PT_W-1:0] mx;
		logic signed [PW_W+PT_W-1:0] my;

		if (o == 1) begin : g_first
			assign prv     = st_in;
			assign prv_ctl = ctl_in;
		end else begin : g_rest
			assign prv     = st_s[o-1];
			assign prv_ctl = ctl_s[o-1];
		end

		always_comb begin
			mx        = $signed(prv.px[o-1]) * $signed(prv.x);
			my        = $signed(prv.py[o-1]) * $signed(prv.y);
			nxt       = prv;
			nxt.px[o] = PW_W'((mx + RND15) >>> 15);
			nxt.py[o] = PW_W'((my + RND15) >>> 15);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[o] <= '0;
			end else if (adv) begin
				ctl_s[o] <= prv_ctl;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[o] <= nxt;
			end
		end
	end

	assign ctl_out = ctl_s[MAX_ORDER];
	assign ld_out  = st_s[MAX_ORDER].ld;
	assign px_out  = st_s[MAX_ORDER].px;
	assign py_out  = st_s[MAX_ORDER].py;

endmodule

@@ sv/rdm_term.sv @@
// Monomial and coefficient stages, with the coefficient registers.
module rdm_term #(
	parameter  int MAX_ORDER = rdm_pkg::MAX_ORDER_DEF,
	localparam int TERMS     = rdm_pkg::terms_of(MAX_ORDER)
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  logic                                                       adv,
	input  logic [rdm_pkg::ORD_W-1:0]                                  order,
	input  rdm_pkg::ctl_t                                              ctl_in,
	input  rdm_pkg::load_t                                             ld_in,
	input  logic [MAX_ORDER:0][rdm_pkg::PW_W-1:0]                      px_in,
	input  logic [MAX_ORDER:0][rdm_pkg::PW_W-1:0]                      py_in,
	output rdm_pkg::ctl_t                                              ctl_out,
	output logic [rdm_pkg::NPOLY-1:0][TERMS-1:0][rdm_pkg::TERM_W-1:0] term_out
);
	import rdm_pkg::*;

	localparam logic signed [2*PW_W-1:0] RND30 = (2*PW_W)'(1) << 29;
	localparam logic signed [2*PW_W-1:0] RND24 = (2*PW_W)'(1) << 23;

	logic [PW_W-1:0]   mono_s1 [TERMS];
	load_t             ld_s1;
	ctl_t              ctl_s1;
	logic [COEF_W-1:0] coef_q  [NPOLY][TERMS];
	logic [TERM_W-1:0] term_s2 [NPOLY][TERMS];
	ctl_t              ctl_s2;
	logic [3:0]        ord_c;
	logic              wr_en;

	always_comb begin
		if (order == '0) begin
			ord_c = 4'd1;
		end else if ({1'b0, order} > 4'(MAX_ORDER)) begin
			ord_c = 4'(MAX_ORDER);
		end else begin
			ord_c = {1'b0, order};
		end
	end

	assign wr_en = adv && ctl_s1.vld && (ctl_s1.map == MODE_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= '{vld: ctl_s1.vld && (ctl_s1.map == MODE_MAP), map: ctl_s1.map};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ld_s1 <= ld_in;
		end
	end

	for (genvar n = 0; n < TERMS; n++) begin : g_mono
		localparam int DEG = deg_of(n);
		localparam int JX  = jx_of(n);
		logic signed [2*PW_W-1:0] mp;

		assign mp = $signed(px_in[JX]) * $signed(py_in[DEG-JX]);

		always_ff @(posedge clk) begin
			if (adv) begin
				mono_s1[n] <= PW_W'((mp + RND30) >>> 30);
			end
		end
	end

	for (genvar p = 0; p < NPOLY; p++) begin : g_poly
		for (genvar n = 0; n < TERMS; n++) begin : g_coef
			localparam int DEG = deg_of(n);
			logic signed [2*COEF_W-1:0] tp;
			logic                       keep;

			assign tp   = $signed(coef_q[p][n]) * $signed(mono_s1[n]);
			assign keep = 4'(DEG) <= ord_c;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q[p][n] <= init_coef(p, n);
				end else if (wr_en && ld_s1.poly == POLY_W'(p) && 8'(ld_s1.idx) == 8'(n)) begin
					coef_q[p][n] <= ld_s1.val;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					term_s2[p][n] <= keep ? TERM_W'((tp + RND24) >>> 24) : '0;
				end
			end

			assign term_out[p][n] = term_s2[p][n];
		end
	end

	assign ctl_out = ctl_s2;

endmodule

@@ sv/rdm_sum.sv @@
// Registered adder trees for the three sums, then sign and magnitude split.
module rdm_sum #(
	parameter  int MAX_ORDER = rdm_pkg::MAX_ORDER_DEF,
	localparam int TERMS     = rdm_pkg::terms_of(MAX_ORDER),
	localparam int ACC_W     = rdm_pkg::TERM_W + $clog2(TERMS)
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  logic                                                       adv,
	input  rdm_pkg::ctl_t                                              ctl_in,
	input  logic [rdm_pkg::NPOLY-1:0][TERMS-1:0][rdm_pkg::TERM_W-1:0] term_in,
	output rdm_pkg::ctl_t                                              ctl_out,
	output logic [1:0][ACC_W-1:0]                                      a_out,
	output logic [ACC_W-1:0]                                           b_out,
	output logic [1:0]                                                 neg_out,
	output logic                                                       zero_out
);
	import rdm_pkg::*;

	localparam int LV = $clog2(TERMS);

	logic signed [ACC_W-1:0] lv0    [NPOLY][TERMS];
	logic signed [ACC_W-1:0] tree_s [1:LV][NPOLY][TERMS];
	ctl_t                    tctl_s [1:LV];
	logic [1:0][ACC_W-1:0]   mag_s;
	logic [ACC_W-1:0]        dmag_s;
	logic [1:0]              neg_s;
	logic                    zero_s;
	ctl_t                    ctl_s;
	logic signed [ACC_W-1:0] root [NPOLY];

	always_comb begin
		for (int p = 0; p < NPOLY; p++) begin
			for (int n = 0; n < TERMS; n++) begin
				lv0[p][n] = ACC_W'($signed(term_in[p][n]));
			end
		end
	end

	for (genvar l = 1; l <= LV; l++) begin : g_lvl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tctl_s[l] <= '0;
			end else if (adv) begin
				tctl_s[l] <= (l == 1) ? ctl_in : tctl_s[l == 1 ? 1 : l-1];
			end
		end

		for (genvar p = 0; p < NPOLY; p++) begin : g_p
			for (genvar i = 0; i < TERMS; i++) begin : g_i
				logic signed [ACC_W-1:0] pa;
				logic signed [ACC_W-1:0] pb;

				if (l == 1) begin : g_first
					if (2*i < TERMS) begin : g_a
						assign pa = lv0[p][2*i];
					end else begin : g_az
						assign pa = '0;
					end
					if (2*i+1 < TERMS) begin : g_b
						assign pb = lv0[p][2*i+1];
					end else begin : g_bz
						assign pb = '0;
					end
				end else begin : g_rest
					if (2*i < TERMS) begin : g_a
						assign pa = tree_s[l-1][p][2*i];
					end else begin : g_az
						assign pa = '0;
					end
					if (2*i+1 < TERMS) begin : g_b
						assign pb = tree_s[l-1][p][2*i+1];
					end else begin : g_bz
						assign pb = '0;
					end
				end

				always_ff @(posedge clk) begin
					if (adv) begin
						tree_s[l][p][i] <= pa + pb;
					end
				end
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NPOLY; p++) begin
			root[p] = tree_s[LV][p][0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (adv) begin
			ctl_s <= tctl_s[LV];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				mag_s[l] <= root[l][ACC_W-1] ? ACC_W'(-root[l]) : ACC_W'(root[l]);
				neg_s[l] <= root[l][ACC_W-1] ^ root[POLY_DEN][ACC_W-1];
			end
			dmag_s <= root[POLY_DEN][ACC_W-1] ? ACC_W'(-root[POLY_DEN]) : ACC_W'(root[POLY_DEN]);
			zero_s <= root[POLY_DEN] == '0;
		end
	end

	assign ctl_out  = ctl_s;
	assign a_out    = mag_s;
	assign b_out    = dmag_s;
	assign neg_out  = neg_s;
	assign zero_out = zero_s;

endmodule

@@ sv/rdm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module rdm_div #(
	parameter  int MAX_ORDER = rdm_pkg::MAX_ORDER_DEF,
	localparam int TERMS     = rdm_pkg::terms_of(MAX_ORDER),
	localparam int ACC_W     = rdm_pkg::TERM_W + $clog2(TERMS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  rdm_pkg::ctl_t                     ctl_in,
	input  logic [1:0][ACC_W-1:0]             a_in,
	input  logic [ACC_W-1:0]                  b_in,
	input  logic [1:0]                        neg_in,
	input  logic                              zero_in,
	output rdm_pkg::ctl_t                     ctl_out,
	output logic [1:0][rdm_pkg::QB-1:0]       q_out,
	output logic [1:0]                        ovf_out,
	output logic [1:0]                        neg_out,
	output logic                              zero_out
);
	import rdm_pkg::*;

	localparam int NW = ACC_W + 18;
	localparam int DW = ACC_W + 1;

	logic [1:0][DW-1:0] rem_s  [0:QB-1];
	logic [1:0][QB-1:0] lo_s   [0:QB-1];
	logic [DW-1:0]      d_s    [0:QB-1];
	logic [1:0][QB-1:0] q_s    [1:QB];
	logic [1:0]         ovf_s  [0:QB];
	logic [1:0]         neg_s  [0:QB];
	logic               zero_s [0:QB];
	ctl_t               ctl_s  [0:QB];

	logic [1:0][NW-1:0] num_c;
	logic [DW-1:0]      den_c;
	logic [1:0]         ovf_c;

	always_comb begin
		den_c = {b_in, 1'b0};
		for (int l = 0; l < 2; l++) begin
			num_c[l] = NW'({a_in[l], 17'b0}) + NW'(b_in);
			ovf_c[l] = DW'(num_c[l][NW-1:QB]) >= den_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= DW'(num_c[l][NW-1:QB]);
				lo_s[0][l]  <= num_c[l][QB-1:0];
			end
			d_s[0]    <= den_c;
			ovf_s[0]  <= ovf_c;
			neg_s[0]  <= neg_in;
			zero_s[0] <= zero_in;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_bit
		logic [1:0][DW:0]   r2;
		logic [1:0][DW:0]   dif;
		logic [1:0]         ge;

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l]  = {rem_s[i-1][l], lo_s[i-1][l][QB-i]};
				dif[l] = r2[l] - {1'b0, d_s[i-1]};
				ge[l]  = r2[l] >= {1'b0, d_s[i-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (adv) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					if (i == 1) begin
						q_s[i][l] <= QB'(ge[l]);
					end else begin
						q_s[i][l] <= {q_s[i == 1 ? 1 : i-1][l][QB-2:0], ge[l]};
					end
				end
				ovf_s[i]  <= ovf_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end

		if (i < QB) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int l = 0; l < 2; l++) begin
						rem_s[i][l] <= ge[l] ? DW'(dif[l]) : DW'(r2[l]);
					end
					lo_s[i] <= lo_s[i-1];
					d_s[i]  <= d_s[i-1];
				end
			end
		end
	end

	assign ctl_out  = ctl_s[QB];
	assign q_out    = q_s[QB];
	assign ovf_out  = ovf_s[QB];
	assign neg_out  = neg_s[QB];
	assign zero_out = zero_s[QB];

endmodule

@@ sv/rational_distortion_map.sv @@
// Top level of the rational distortion map: pipeline, configuration register and result stage.
// The block takes one request per clock while the result is not stalled and returns one result
// per map request. TERMS, the number of terms per polynomial, is (MAX_ORDER+1)(MAX_ORDER+2)/2,
// and the 32 one-bit stages of the quotient divider make up most of the pipeline.
// A coefficient load request produces no result and takes effect in order with map requests.
// The whole pipeline advances whenever the result register is empty or being taken, so a
// stalled result holds every stage and request ready drops with it. The order register is
// written through cfg_we and cfg_wdata and must only change while no request is in flight.
`include "rational_distortion_map_defines.svh"

module rational_distortion_map #(
	parameter int MAX_ORDER = rdm_pkg::MAX_ORDER_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rdm_pkg::ORD_W-1:0]  cfg_wdata,
	rdm_in_if.sink                     req,
	rdm_out_if.source                  result
);
	import rdm_pkg::*;

	localparam int TERMS = terms_of(MAX_ORDER);
	localparam int ACC_W = TERM_W + $clog2(TERMS);

	logic                               adv;
	logic [ORD_W-1:0]                   order_q;
	ctl_t                               ctl_in;
	load_t                              ld_in;

	ctl_t                               pow_ctl;
	load_t                              pow_ld;
	logic [MAX_ORDER:0][PW_W-1:0]       pow_px;
	logic [MAX_ORDER:0][PW_W-1:0]       pow_py;

	ctl_t                               term_ctl;
	logic [NPOLY-1:0][TERMS-1:0][TERM_W-1:0] term_val;

	ctl_t                               sum_ctl;
	logic [1:0][ACC_W-1:0]              sum_a;
	logic [ACC_W-1:0]                   sum_b;
	logic [1:0]                         sum_neg;
	logic                               sum_zero;

	ctl_t                               div_ctl;
	logic [1:0][QB-1:0]                 div_q;
	logic [1:0]                         div_ovf;
	logic [1:0]                         div_neg;
	logic                               div_zero;

	logic [1:0]                         sat_c;
	logic [1:0][OUT_W-1:0]              val_c;

	logic                               out_vld_q;
	logic [OUT_W-1:0]                   x_q;
	logic [OUT_W-1:0]                   y_q;
	logic [ST_W-1:0]                    st_q;

	assign adv       = !out_vld_q || result.ready;
	assign req.ready = adv;
	assign ctl_in    = '{vld: req.valid, map: req.mode};
	assign ld_in     = '{poly: req.coef_poly, idx: req.coef_index, val: req.coef_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_W'(1);
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	rdm_pow #(.MAX_ORDER(MAX_ORDER)) u_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_in),
		.ld_in   (ld_in),
		.x_in    (req.x_in),
		.y_in    (req.y_in),
		.ctl_out (pow_ctl),
		.ld_out  (pow_ld),
		.px_out  (pow_px),
		.py_out  (pow_py)
	);

	rdm_term #(.MAX_ORDER(MAX_ORDER)) u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.order    (order_q),
		.ctl_in   (pow_ctl),
		.ld_in    (pow_ld),
		.px_in    (pow_px),
		.py_in    (pow_py),
		.ctl_out  (term_ctl),
		.term_out (term_val)
	);

	rdm_sum #(.MAX_ORDER(MAX_ORDER)) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_in   (term_ctl),
		.term_in  (term_val),
		.ctl_out  (sum_ctl),
		.a_out    (sum_a),
		.b_out    (sum_b),
		.neg_out  (sum_neg),
		.zero_out (sum_zero)
	);

	rdm_div #(.MAX_ORDER(MAX_ORDER)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_in   (sum_ctl),
		.a_in     (sum_a),
		.b_in     (sum_b),
		.neg_in   (sum_neg),
		.zero_in  (sum_zero),
		.ctl_out  (div_ctl),
		.q_out    (div_q),
		.ovf_out  (div_ovf),
		.neg_out  (div_neg),
		.zero_out (div_zero)
	);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [OUT_W-1:0] lim;
			logic [OUT_W-1:0] mag;
			lim      = div_neg[l] ? OUT_MIN : OUT_MAX;
			sat_c[l] = div_ovf[l] || (div_q[l] > lim);
			mag      = sat_c[l] ? lim : div_q[l];
			val_c[l] = div_neg[l] ? OUT_W'(-mag) : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_zero) begin
				x_q  <= '0;
				y_q  <= '0;
				st_q <= ST_DEN_ZERO;
			end else begin
				x_q  <= val_c[0];
				y_q  <= val_c[1];
				st_q <= (sat_c != 2'b00) ? ST_SAT : ST_OK;
			end
		end
	end

	assign result.valid  = out_vld_q;
	assign result.x_out  = x_q;
	assign result.y_out  = y_q;
	assign result.status = st_q;

	`RDM_ASSERT_NOW(a_stall_blocks_req, clk, arst_n, result.valid && !result.ready, !req.ready, "request taken while a result is stalled")
	`RDM_ASSERT_NOW(a_den_zero_clears, clk, arst_n, result.valid && result.status == ST_DEN_ZERO, result.x_out == '0 && result.y_out == '0, "zero denominator with nonzero output")
	`RDM_ASSERT_NOW(a_sat_at_limit, clk, arst_n, result.valid && result.status == ST_SAT, x_q == OUT_MAX || x_q == OUT_MIN || y_q == OUT_MAX || y_q == OUT_MIN, "saturation flagged without a limit value")
	`RDM_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_we, order_q == $past(cfg_wdata), "order register missed a write")

endmodule
